@@ hdl/ascr_pkg.sv @@
// ----------------------------------------------------------------------------
// ascr_pkg
// Shared types and constants for the auxiliary system control registers.
// ----------------------------------------------------------------------------
package ascr_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_PFAIL  = 2'd2,
        OP_SRESET = 2'd3
    } t_opcode;

    // Register regions
    localparam logic [2:0] RGN_CONFIG  = 3'd0;
    localparam logic [2:0] RGN_DIAG    = 3'd1;
    localparam logic [2:0] RGN_MODEM   = 3'd2;
    localparam logic [2:0] RGN_LEDS    = 3'd3;
    localparam logic [2:0] RGN_SYSCTRL = 3'd4;
    localparam logic [2:0] RGN_AUX1    = 3'd5;
    localparam logic [2:0] RGN_AUX2    = 3'd6;

    // Register bit masks
    localparam logic [7:0] AUX1_TC         = 8'h02;
    localparam logic [7:0] AUX2_PWR_DOWN   = 8'h01;
    localparam logic [7:0] AUX2_FAIL_CLR   = 8'h02;
    localparam logic [7:0] AUX2_FAIL_FLAG  = 8'h20;
    localparam logic [7:0] CFG_FAIL_IRQ_EN = 8'h08;
    localparam logic [7:0] SYSCTL_RST_REQ  = 8'h01;
    localparam logic [1:0] SYSCTL_RST_FLAG = 2'h2;

    // Packed stream widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    // One request item
    typedef struct packed {
        t_opcode     opcode;
        logic [2:0]  region;
        logic [1:0]  offset;
        logic [31:0] write_data;
        logic        pfail_level;
    } t_req;

    // One result item
    typedef struct packed {
        logic [15:0] read_data;
        logic        interrupt_level;
        logic        floppy_tc_pulse;
        logic        shutdown_request;
        logic        reset_request;
    } t_rsp;

endpackage

@@ hdl/ascr_in_stage.sv @@
// ----------------------------------------------------------------------------
// ascr_in_stage
// Input register: captures one request transfer and holds it until the
// register file consumes it.
// ----------------------------------------------------------------------------
module ascr_in_stage import ascr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    input  logic i_advance,   // held request moves on this cycle
    output logic o_valid,
    output t_req o_req
);

    logic r_valid;
    t_req r_req;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

@@ hdl/ascr_regfile.sv @@
// ----------------------------------------------------------------------------
// ascr_regfile
// Register state and the single-pass update/read logic for one request.
// State is committed when the request moves into the result register.
// ----------------------------------------------------------------------------
module ascr_regfile import ascr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_req i_req,
    output t_rsp o_rsp
);

    logic [7:0]  r_config, n_config;
    logic [7:0]  r_diag, n_diag;
    logic [7:0]  r_modem, n_modem;
    logic [7:0]  r_aux1, n_aux1;
    logic [7:0]  r_aux2, n_aux2;
    logic [1:0]  r_sysstat, n_sysstat;
    logic [15:0] r_leds, n_leds;

    logic        wr_en;
    logic [7:0]  wbyte;
    logic [7:0]  aux2_wr;
    logic [15:0] rd_val;

    assign wr_en = (i_req.opcode == OP_WRITE) && (i_req.offset == 2'd0);
    assign wbyte = i_req.write_data[7:0];

    // Aux2 write value: take power-off and keep the latched fail flag; a set clear bit drops the fail flag
    always_comb begin
        aux2_wr = (wbyte & (AUX2_FAIL_CLR | AUX2_PWR_DOWN)) | (r_aux2 & AUX2_FAIL_FLAG);
        if ((aux2_wr & AUX2_FAIL_CLR) != 8'h00) begin
            aux2_wr = aux2_wr & AUX2_PWR_DOWN;
        end
    end

    // Read mux, current state
    always_comb begin
        unique case (i_req.region)
            RGN_CONFIG:  rd_val = {8'h00, r_config};
            RGN_DIAG:    rd_val = {8'h00, r_diag};
            RGN_MODEM:   rd_val = {8'h00, r_modem};
            RGN_LEDS:    rd_val = r_leds;
            RGN_SYSCTRL: rd_val = {14'h0000, r_sysstat};
            RGN_AUX1:    rd_val = {8'h00, r_aux1};
            RGN_AUX2:    rd_val = {8'h00, r_aux2};
            default:     rd_val = 16'h0000;
        endcase
    end

    // Next state and side-effect strobes
    always_comb begin
        n_config  = r_config;
        n_diag    = r_diag;
        n_modem   = r_modem;
        n_aux1    = r_aux1;
        n_aux2    = r_aux2;
        n_sysstat = r_sysstat;
        n_leds    = r_leds;
        o_rsp     = '0;

        unique case (i_req.opcode)
            OP_READ: begin
                if (i_req.offset == 2'd0) begin
                    o_rsp.read_data = rd_val;
                end
            end
            OP_WRITE: begin
                if (wr_en) begin
                    unique case (i_req.region)
                        RGN_CONFIG: n_config = wbyte;
                        RGN_DIAG:   n_diag   = wbyte;
                        RGN_MODEM:  n_modem  = wbyte;
                        RGN_LEDS:   n_leds   = i_req.write_data[15:0];
                        RGN_SYSCTRL: begin
                            if ((wbyte & SYSCTL_RST_REQ) != 8'h00) begin
                                n_sysstat           = SYSCTL_RST_FLAG;
                                o_rsp.reset_request = 1'b1;
                            end
                        end
                        RGN_AUX1: begin
                            o_rsp.floppy_tc_pulse = (wbyte & AUX1_TC) != 8'h00;
                            n_aux1                = wbyte & ~AUX1_TC;
                        end
                        RGN_AUX2: begin
                            n_aux2                 = aux2_wr;
                            o_rsp.shutdown_request = (aux2_wr & AUX2_PWR_DOWN) != 8'h00;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_PFAIL: begin
                if (i_req.pfail_level && ((r_config & CFG_FAIL_IRQ_EN) != 8'h00)) begin
                    n_aux2 = r_aux2 | AUX2_FAIL_FLAG;
                end else begin
                    n_aux2 = r_aux2 & ~AUX2_FAIL_FLAG;
                end
            end
            OP_SRESET: begin
                n_config = 8'h00;
                n_aux1   = 8'h00;
                n_aux2   = 8'h00;
                n_modem  = 8'h00;
            end
            default: begin
            end
        endcase

        // Interrupt level after this item
        o_rsp.interrupt_level = ((n_aux2 & AUX2_FAIL_FLAG) != 8'h00)
                              && ((n_config & CFG_FAIL_IRQ_EN) != 8'h00);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_config  <= 8'h00;
            r_diag    <= 8'h00;
            r_modem   <= 8'h00;
            r_aux1    <= 8'h00;
            r_aux2    <= 8'h00;
            r_sysstat <= 2'h0;
            r_leds    <= 16'h0000;
        end else if (i_fire) begin
            r_config  <= n_config;
            r_diag    <= n_diag;
            r_modem   <= n_modem;
            r_aux1    <= n_aux1;
            r_aux2    <= n_aux2;
            r_sysstat <= n_sysstat;
            r_leds    <= n_leds;
        end
    end

endmodule

@@ hdl/ascr_out_stage.sv @@
// ----------------------------------------------------------------------------
// ascr_out_stage
// Result register: holds one result until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module ascr_out_stage import ascr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_rsp i_rsp,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    logic r_valid;
    t_rsp r_rsp;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

@@ hdl/aux_system_control_registers.sv @@
// ----------------------------------------------------------------------------
// aux_system_control_registers
// Auxiliary system registers with power-fail interrupt, stream interface.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the kind (read,
//   write, power-fail level change, soft reset), tdata the register select,
//   offset, write data and power-fail level. Every request gives exactly one
//   result on m_axis: read data, interrupt level and the three strobes
//   (floppy terminal count, shutdown request, reset request).
//   An accepted request goes through the input register and then the
//   result register to reach m_axis. The register update and read are
//   one pass of logic between the two.
//   Throughput is one request per cycle; s_axis_tready stays high while the
//   result register can move on.
//   When the receiver holds m_axis_tready low the result is held, the input
//   register fills, and s_axis_tready drops after that; no result is lost.
//   Reset (i_rst_n low, synchronous) empties both stages and clears every
//   register. Soft reset requests clear config, modem, aux1 and aux2 only.
// ----------------------------------------------------------------------------
module aux_system_control_registers import ascr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] region, [4:3] offset, [36:5] write_data, [37] pfail_level
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [15:0] read_data, [16] interrupt_level, [17] floppy_tc_pulse,
    // [18] shutdown_request, [19] reset_request
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_req in_req;
    t_req held_req;
    t_rsp calc_rsp;
    t_rsp out_rsp;
    logic held_valid;
    logic out_ready;
    logic fire;

    // Unpack request fields
    assign in_req.opcode      = t_opcode'(s_axis_tuser);
    assign in_req.region      = s_axis_tdata[2:0];
    assign in_req.offset      = s_axis_tdata[4:3];
    assign in_req.write_data  = s_axis_tdata[36:5];
    assign in_req.pfail_level = s_axis_tdata[37];

    assign fire = held_valid && out_ready;

    ascr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_req     (in_req),
        .i_advance (out_ready),
        .o_valid   (held_valid),
        .o_req     (held_req)
    );

    ascr_regfile u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (held_req),
        .o_rsp   (calc_rsp)
    );

    ascr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (held_valid),
        .o_ready (out_ready),
        .i_rsp   (calc_rsp),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rsp   (out_rsp)
    );

    // Pack result fields
    assign m_axis_tdata = {4'h0, out_rsp.reset_request, out_rsp.shutdown_request,
                           out_rsp.floppy_tc_pulse, out_rsp.interrupt_level,
                           out_rsp.read_data};

endmodule

@@ hdl/ascr_checker.sv @@
// ----------------------------------------------------------------------------
// ascr_checker
// Port-level checks for the auxiliary system control registers.
// ----------------------------------------------------------------------------
module ascr_checker import ascr_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Strobes come from distinct register writes
    a_strobe_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[19:17]))
        else $error("more than one strobe in one result");

    // Write strobes never carry read data
    a_strobe_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[19:17] != 3'b000) |-> m_axis_tdata[15:0] == 16'h0000)
        else $error("read data on a write result");

    // Input side opens once the result register drains
    a_accept_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");

endmodule

bind aux_system_control_registers ascr_checker u_ascr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
